### hw/rtl/bitmap_page_allocator_defines.svh
// Assertion macros for the bitmap page allocator checker.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef BITMAP_PAGE_ALLOCATOR_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define BPA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bpa check failed");

// next-cycle implication
`define BPA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bpa check failed");

`endif

### hw/rtl/bpa_pkg.sv
// Shared constants, codes and control structs of the bitmap page allocator.
// No dependencies.
`default_nettype none

package bpa_pkg;

  localparam int ADDR_W         = 56;
  localparam int SIZE_W         = 13;
  localparam int MAP_W          = 64;
  localparam int BIT_W          = 6;
  localparam int CFG_IDX_W      = 2;
  localparam int DEF_POOL_PAGES = 4096;
  localparam int DEF_PAGE_BYTES = 4096;

  localparam logic [SIZE_W-1:0] SIZE_RST = 13'd4096;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_PAGE  = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USER_BASE   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_USER_SIZE   = 2'd3;

  typedef struct packed {
    logic take;
    logic scan_rd;
    logic alloc_commit;
    logic no_page;
    logic free_check;
    logic free_rd;
    logic free_wr;
    logic clr_wr;
    logic out_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic rd_more;
    logic chk_valid;
    logic hit;
    logic free_ok;
  } dp_stat_t;

endpackage

`default_nettype wire

### hw/rtl/bpa_ctrl.sv
// Controller state machine of the bitmap page allocator.
// Depends on bpa_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  input  wire logic     in_command,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire dp_stat_t stat,
  output ctl_cmd_t      cmd
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FCHK  = 3'd3;
  localparam logic [2:0] S_FRD   = 3'd4;
  localparam logic [2:0] S_FWR   = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = (in_command == CMD_FREE) ? S_FCHK : S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          cmd.alloc_commit = 1'b1;
          state_nxt        = S_DONE;
        end else if (!stat.chk_valid && !stat.rd_more) begin
          cmd.no_page = 1'b1;
          state_nxt   = S_DONE;
        end else begin
          cmd.scan_rd = stat.rd_more;
        end
      end
      S_FCHK: begin
        cmd.free_check = 1'b1;
        state_nxt      = stat.free_ok ? S_FRD : S_DONE;
      end
      S_FRD: begin
        cmd.free_rd = 1'b1;
        state_nxt   = S_FWR;
      end
      S_FWR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

### hw/rtl/bpa_datapath.sv
// Datapath of the bitmap page allocator: config registers, bitmap memory,
// word scan, free address check and result registers. Depends on bpa_pkg.
`default_nettype none

module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = DEF_POOL_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 in_pool_kernel,
  input  wire logic [ADDR_W-1:0]    in_page_address,
  input  wire ctl_cmd_t             cmd,
  output dp_stat_t                  stat,
  output logic [ADDR_W-1:0]         out_result_address,
  output logic [1:0]                out_status
);

  localparam int WORDS      = (POOL_PAGES + MAP_W - 1) / MAP_W;
  localparam int WORD_IDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int ROW_W      = WORD_IDX_W + 1;
  localparam int ROWS       = 2 << WORD_IDX_W;
  localparam int WC_W       = WORD_IDX_W + 1;
  localparam int PG_W       = WORD_IDX_W + BIT_W;
  localparam int PGX_W      = PG_W + 1;
  localparam int LIM_W      = $clog2(POOL_PAGES + 1);
  localparam int CW         = (LIM_W > SIZE_W) ? LIM_W : SIZE_W;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int HI_W       = ADDR_W - PAGE_SHIFT;

  // config
  logic [ADDR_W-1:0] kbase_r, ubase_r;
  logic [SIZE_W-1:0] ksize_r, usize_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kbase_r <= '0;
      ubase_r <= '0;
      ksize_r <= SIZE_RST;
      usize_r <= SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_BASE: kbase_r <= cfg_data;
        REG_USER_BASE:   ubase_r <= cfg_data;
        REG_KERNEL_SIZE: ksize_r <= cfg_data[SIZE_W-1:0];
        REG_USER_SIZE:   usize_r <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // latched word
  logic              pool_r;
  logic [ADDR_W-1:0] addr_r;

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      pool_r <= in_pool_kernel;
      addr_r <= in_page_address;
    end
  end

  logic [ADDR_W-1:0] base;
  logic [SIZE_W-1:0] size_sel;
  logic [CW-1:0]     size_ext, lim_c;
  logic [LIM_W-1:0]  lim;

  assign base     = pool_r ? kbase_r : ubase_r;
  assign size_sel = pool_r ? ksize_r : usize_r;
  assign size_ext = CW'(size_sel);
  assign lim_c    = (size_ext > CW'(POOL_PAGES)) ? CW'(POOL_PAGES) : size_ext;
  assign lim      = lim_c[LIM_W-1:0];

  // scan pointers
  logic [WC_W-1:0]       rd_word_r, rd_word_nxt;
  logic [WORD_IDX_W-1:0] chk_word_r;
  logic                  chk_valid_r;
  logic [ROW_W-1:0]      clr_r;

  always_comb begin
    rd_word_nxt = rd_word_r;
    if (cmd.take) rd_word_nxt = '0;
    else if (cmd.scan_rd) rd_word_nxt = rd_word_r + WC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_word_r   <= '0;
      chk_valid_r <= 1'b0;
      clr_r       <= '0;
    end else begin
      rd_word_r   <= rd_word_nxt;
      chk_valid_r <= cmd.scan_rd;
      if (cmd.clr_wr) clr_r <= clr_r + ROW_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_rd) chk_word_r <= rd_word_r[WORD_IDX_W-1:0];
  end

  // bitmap memory, row = {pool, word}
  logic [MAP_W-1:0] mem [ROWS];
  logic [MAP_W-1:0] rdata_r;
  logic [PG_W-1:0]  free_page_r;

  logic             mem_we, mem_re;
  logic [ROW_W-1:0] waddr, raddr;
  logic [MAP_W-1:0] wdata;

  // word check
  logic [PGX_W-1:0] rem;
  logic             rem_full;
  logic [MAP_W-1:0] lo_mask, vmask, masked;
  logic [BIT_W-1:0] fb;
  logic             found;
  logic [PG_W-1:0]  hit_page;
  logic [BIT_W-1:0] free_bit;

  assign rem      = PGX_W'(lim) - {1'b0, chk_word_r, {BIT_W{1'b0}}};
  assign rem_full = (rem[PGX_W-1:BIT_W] != '0);
  assign lo_mask  = (MAP_W'(1) << rem[BIT_W-1:0]) - MAP_W'(1);
  assign vmask    = rem_full ? {MAP_W{1'b1}} : lo_mask;
  assign masked   = rdata_r | ~vmask;
  assign found    = ~&masked;

  always_comb begin
    fb = '0;
    for (int b = MAP_W - 1; b >= 0; b--) begin
      if (!masked[b]) fb = BIT_W'(b);
    end
  end

  assign hit_page = {chk_word_r, fb};
  assign free_bit = free_page_r[BIT_W-1:0];

  always_comb begin
    mem_we = cmd.clr_wr | cmd.alloc_commit | cmd.free_wr;
    mem_re = cmd.scan_rd | cmd.free_rd;
    waddr  = clr_r;
    wdata  = '0;
    if (cmd.alloc_commit) begin
      waddr = {pool_r, chk_word_r};
      wdata = rdata_r | (MAP_W'(1) << fb);
    end else if (cmd.free_wr) begin
      waddr = {pool_r, free_page_r[PG_W-1:BIT_W]};
      wdata = rdata_r & ~(MAP_W'(1) << free_bit);
    end
    if (cmd.scan_rd) raddr = {pool_r, rd_word_r[WORD_IDX_W-1:0]};
    else             raddr = {pool_r, free_page_r[PG_W-1:BIT_W]};
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    if (mem_re) rdata_r <= mem[raddr];
  end

  // free address check
  logic [ADDR_W-1:0] off;
  logic [HI_W-1:0]   idx_hi;
  logic              free_ok;

  assign off     = addr_r - base;
  assign idx_hi  = off[ADDR_W-1:PAGE_SHIFT];
  assign free_ok = (addr_r >= base) && (idx_hi < HI_W'(lim));

  always_ff @(posedge clk) begin
    if (cmd.free_check) free_page_r <= idx_hi[PG_W-1:0];
  end

  // result
  logic [ADDR_W-1:0] res_addr_r;
  logic [1:0]        res_status_r;
  logic [ADDR_W-1:0] out_addr_r;
  logic [1:0]        out_status_r;

  always_ff @(posedge clk) begin
    if (cmd.alloc_commit) begin
      res_addr_r   <= base + (ADDR_W'(hit_page) << PAGE_SHIFT);
      res_status_r <= ST_OK;
    end else if (cmd.no_page) begin
      res_addr_r   <= '0;
      res_status_r <= ST_NO_PAGE;
    end else if (cmd.free_check) begin
      res_addr_r   <= '0;
      res_status_r <= free_ok ? ST_OK : ST_BAD_ADDR;
    end
    if (cmd.out_load) begin
      out_addr_r   <= res_addr_r;
      out_status_r <= res_status_r;
    end
  end

  assign out_result_address = out_addr_r;
  assign out_status         = out_status_r;

  assign stat.clr_last  = (clr_r == {ROW_W{1'b1}});
  assign stat.rd_more   = ({rd_word_r, {BIT_W{1'b0}}} < PGX_W'(lim));
  assign stat.chk_valid = chk_valid_r;
  assign stat.hit       = chk_valid_r & found;
  assign stat.free_ok   = free_ok;

endmodule

`default_nettype wire

### hw/rtl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller plus datapath.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//   channel  handshake              word
//   in       in_valid / in_ready    command, pool_kernel, page_address
//   out      out_valid / out_ready  result_address, status
//   cfg      cfg_we                 cfg_index, cfg_data
//
// Allocate: the 64-bit map words are read from word 0, one word read per cycle, and the lowest
// free page below the pool size is taken; a full pool or size 0 ends with status no page.
// Free: address check, read, write back, output load; a bad address goes from check to output load.
// After reset a clearing pass zeroes the map rows of both pools; no word is accepted meanwhile.
// A waiting result does not block the next accept; that word then holds until out_ready.
`default_nettype none

module bitmap_page_allocator
  import bpa_pkg::*;
#(
  parameter int POOL_PAGES = DEF_POOL_PAGES,
  parameter int PAGE_BYTES = DEF_PAGE_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_command,
  input  wire logic                 in_pool_kernel,
  input  wire logic [ADDR_W-1:0]    in_page_address,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [ADDR_W-1:0]         out_result_address,
  output logic [1:0]                out_status
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  bpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  bpa_datapath #(
    .POOL_PAGES (POOL_PAGES),
    .PAGE_BYTES (PAGE_BYTES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_pool_kernel     (in_pool_kernel),
    .in_page_address    (in_page_address),
    .cmd                (cmd),
    .stat               (stat),
    .out_result_address (out_result_address),
    .out_status         (out_status)
  );

endmodule

`default_nettype wire

### hw/rtl/bpa_checker.sv
// Port-level checker of the bitmap page allocator, bound to the top level.
// Depends on bpa_pkg and bitmap_page_allocator_defines.svh.
`default_nettype none
`include "bitmap_page_allocator_defines.svh"

module bpa_checker
  import bpa_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [ADDR_W-1:0] out_result_address,
  input wire logic [1:0]        out_status
);

  `BPA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  `BPA_ASSERT_IMP(a_status_code, out_valid, out_status <= ST_BAD_ADDR)
  `BPA_ASSERT_IMP(a_fail_zero, out_valid && (out_status != ST_OK), out_result_address == '0)
  `BPA_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready)

endmodule

bind bitmap_page_allocator bpa_checker u_bpa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_result_address (out_result_address),
  .out_status         (out_status)
);

`default_nettype wire

### tb/sv/bitmap_page_allocator_test.sv
// Self-checking testbench for bitmap_page_allocator: directed corner cases, a deep
// fill and random traffic, checked word by word against an in-bench bitmap predictor.
// Depends on bpa_pkg and the bitmap_page_allocator RTL.
`timescale 1ns / 1ps

module bitmap_page_allocator_test;
  import bpa_pkg::*;

  localparam int POOL_PAGES     = DEF_POOL_PAGES;
  localparam int PAGE_BYTES     = DEF_PAGE_BYTES;
  localparam int ITEM_TARGET    = 1700;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_TAIL     = 80;
  localparam int MAX_PRINTS     = 30;

  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    addr_t      address;
    logic [1:0] status;
  } page_answer_t;

  localparam addr_t PAGE_MASK = ~addr_t'(PAGE_BYTES - 1);
  localparam addr_t SIZE_FIELD = addr_t'((1 << SIZE_W) - 1);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  addr_t                cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_command = CMD_ALLOC;
  logic                 in_pool_kernel = 1'b0;
  addr_t                in_page_address = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  addr_t                out_result_address;
  logic [1:0]           out_status;

  bitmap_page_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_command        (in_command),
    .in_pool_kernel    (in_pool_kernel),
    .in_page_address   (in_page_address),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_address(out_result_address),
    .out_status        (out_status)
  );

  always #5 clk = ~clk;

  // predictor state, index 1 = kernel pool, 0 = user pool
  bit                taken_map [2][POOL_PAGES];
  addr_t             pool_base [2];
  logic [SIZE_W-1:0] pool_size [2];

  page_answer_t answers_due[$];
  addr_t        live_kernel[$];
  addr_t        live_user[$];
  int           words_sent = 0;
  int           mismatches = 0;
  int           idle_cycles = 0;
  int           stall_left = 0;
  bit           no_idle = 1'b0;

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTS) $display("mismatch @%0t: %s", $realtime, what);
  endtask

  function automatic addr_t rand_addr();
    return addr_t'({$urandom(), $urandom()});
  endfunction

  function automatic int usable_pages(logic kern);
    return (int'(pool_size[kern]) > POOL_PAGES) ? POOL_PAGES : int'(pool_size[kern]);
  endfunction

  function automatic void push_live(logic kern, addr_t a);
    if (kern) live_kernel.push_back(a);
    else live_user.push_back(a);
  endfunction

  function automatic void rebuild_live_pages();
    int limit;
    live_kernel.delete();
    live_user.delete();
    for (int p = 0; p < 2; p++) begin
      limit = usable_pages(p[0]);
      for (int i = 0; i < limit; i++)
        if (taken_map[p][i]) push_live(p[0], pool_base[p] + addr_t'(i) * addr_t'(PAGE_BYTES));
    end
  endfunction

  function automatic page_answer_t predict_page_request(logic cmd, logic kern, addr_t addr);
    page_answer_t ans;
    addr_t        base;
    addr_t        index;
    int           limit;
    base = pool_base[kern];
    limit = usable_pages(kern);
    ans.address = '0;
    ans.status = ST_OK;
    if (cmd == CMD_ALLOC) begin
      ans.status = ST_NO_PAGE;
      for (int i = 0; i < limit; i++) begin
        if (!taken_map[kern][i]) begin
          taken_map[kern][i] = 1'b1;
          ans.address = base + addr_t'(i) * addr_t'(PAGE_BYTES);
          ans.status = ST_OK;
          break;
        end
      end
    end else if (addr < base) begin
      ans.status = ST_BAD_ADDR;
    end else begin
      index = (addr - base) / addr_t'(PAGE_BYTES);
      if (index >= addr_t'(limit)) ans.status = ST_BAD_ADDR;
      else taken_map[kern][int'(index)] = 1'b0;
    end
    return ans;
  endfunction

  function automatic int idle_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 50);
  endfunction

  task automatic send_request(logic cmd, logic kern, addr_t addr);
    int           gap;
    page_answer_t ans;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_command      <= cmd;
    in_pool_kernel  <= kern;
    in_page_address <= addr;
    do @(posedge clk); while (!in_ready);
    ans = predict_page_request(cmd, kern, addr);
    answers_due.push_back(ans);
    if (cmd == CMD_ALLOC && ans.status == ST_OK) push_live(kern, ans.address);
    words_sent++;
  endtask

  task automatic wait_for_answers();
    in_valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, addr_t value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_KERNEL_BASE: pool_base[1] = value;
      REG_USER_BASE:   pool_base[0] = value;
      REG_KERNEL_SIZE: pool_size[1] = value[SIZE_W-1:0];
      REG_USER_SIZE:   pool_size[0] = value[SIZE_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic addr_t noise_address(logic kern);
    addr_t base;
    addr_t span;
    base = pool_base[kern];
    span = addr_t'(usable_pages(kern)) * addr_t'(PAGE_BYTES);
    case ($urandom_range(0, 4))
      0: return rand_addr();
      1: return base - 1;
      2: return base + span;
      3: return base + span - 1;
      default: return base + addr_t'($urandom_range(0, usable_pages(kern) + 2) * PAGE_BYTES)
                      + addr_t'($urandom_range(0, PAGE_BYTES - 1));
    endcase
  endfunction

  task automatic free_live_page(logic kern);
    addr_t a;
    int    n;
    n = kern ? live_kernel.size() : live_user.size();
    if (n == 0) begin
      send_request(CMD_FREE, kern, noise_address(kern));
    end else begin
      n = $urandom_range(0, n - 1);
      if (kern) begin
        a = live_kernel[n];
        live_kernel.delete(n);
      end else begin
        a = live_user[n];
        live_user.delete(n);
      end
      if ($urandom_range(0, 1)) a = a + addr_t'($urandom_range(0, PAGE_BYTES - 1));
      send_request(CMD_FREE, kern, a);
    end
  endtask

  function automatic addr_t pick_base();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return rand_addr() & PAGE_MASK;
      4, 5:       return '0;
      6:          return PAGE_MASK - addr_t'($urandom_range(0, 8) * PAGE_BYTES);
      7:          return rand_addr();
      default:    return addr_t'($urandom_range(0, 64) * PAGE_BYTES);
    endcase
  endfunction

  function automatic addr_t pick_size();
    case ($urandom_range(0, 19))
      11:     return '0;
      12:     return addr_t'(POOL_PAGES);
      13:     return addr_t'($urandom_range(POOL_PAGES + 1, (1 << SIZE_W) - 1));
      14:     return SIZE_FIELD;
      15:     return addr_t'($urandom_range(0, POOL_PAGES));
      16, 17: return (rand_addr() & ~SIZE_FIELD) | addr_t'($urandom_range(1, 16));
      18, 19: return addr_t'($urandom_range(100, 300));
      default: return addr_t'($urandom_range(1, 80));
    endcase
  endfunction

  task automatic test_special_cases();
    addr_t ubase;
    ubase = addr_t'(PAGE_BYTES);
    send_request(CMD_ALLOC, 1'b1, rand_addr());
    send_request(CMD_ALLOC, 1'b0, rand_addr());
    send_request(CMD_FREE, 1'b1, '0);
    send_request(CMD_FREE, 1'b0, addr_t'(12'h123));
    send_request(CMD_FREE, 1'b1, '0);
    send_request(CMD_FREE, 1'b0, '1);
    wait_for_answers();
    // kernel pool straddles the top of the address space
    write_register(REG_KERNEL_BASE, PAGE_MASK - addr_t'(PAGE_BYTES));
    write_register(REG_KERNEL_SIZE, SIZE_FIELD);
    write_register(REG_USER_BASE, ubase);
    write_register(REG_USER_SIZE, ~addr_t'(0));
    send_request(CMD_ALLOC, 1'b1, '0);
    send_request(CMD_ALLOC, 1'b1, '1);
    send_request(CMD_ALLOC, 1'b1, rand_addr());
    send_request(CMD_FREE, 1'b1, '0);
    send_request(CMD_FREE, 1'b0, ubase + addr_t'(POOL_PAGES) * addr_t'(PAGE_BYTES));
    send_request(CMD_FREE, 1'b0, ubase + addr_t'(POOL_PAGES) * addr_t'(PAGE_BYTES) - 1);
    send_request(CMD_FREE, 1'b0, ubase - 1);
    wait_for_answers();
    write_register(REG_KERNEL_BASE, '0);
    write_register(REG_KERNEL_SIZE, addr_t'(3));
    send_request(CMD_ALLOC, 1'b1, rand_addr());
    wait_for_answers();
    // shrink below a taken page, then grow back
    write_register(REG_KERNEL_SIZE, addr_t'(1));
    send_request(CMD_FREE, 1'b1, addr_t'(2 * PAGE_BYTES));
    send_request(CMD_ALLOC, 1'b1, rand_addr());
    wait_for_answers();
    write_register(REG_KERNEL_SIZE, addr_t'(3));
    send_request(CMD_FREE, 1'b1, addr_t'(2 * PAGE_BYTES));
    send_request(CMD_ALLOC, 1'b1, rand_addr());
    wait_for_answers();
    write_register(REG_USER_SIZE, '0);
    send_request(CMD_ALLOC, 1'b0, rand_addr());
    send_request(CMD_FREE, 1'b0, ubase);
    wait_for_answers();
  endtask

  task automatic test_deep_fill();
    write_register(REG_KERNEL_BASE, rand_addr() & PAGE_MASK);
    write_register(REG_KERNEL_SIZE, addr_t'(POOL_PAGES));
    write_register(REG_USER_SIZE, addr_t'(POOL_PAGES));
    rebuild_live_pages();
    no_idle = 1'b1;
    for (int i = 0; i < 400; i++) begin
      if (i == 150) no_idle = 1'b0;
      send_request(CMD_ALLOC, 1'b1, rand_addr());
    end
    wait_for_answers();
    for (int i = 0; i < 100; i++) free_live_page(1'b1);
    for (int i = 0; i < 100; i++) send_request(CMD_ALLOC, 1'b1, rand_addr());
    wait_for_answers();
  endtask

  task automatic test_random_traffic();
    int  items;
    int  kern_bias;
    int  alloc_pct;
    int  r;
    logic kern;
    while (words_sent < ITEM_TARGET) begin
      wait_for_answers();
      if ($urandom_range(0, 9) < 7) write_register(REG_KERNEL_BASE, pick_base());
      if ($urandom_range(0, 9) < 7) write_register(REG_USER_BASE, pick_base());
      if ($urandom_range(0, 9) < 7) write_register(REG_KERNEL_SIZE, pick_size());
      if ($urandom_range(0, 9) < 7) write_register(REG_USER_SIZE, pick_size());
      rebuild_live_pages();
      no_idle = ($urandom_range(0, 3) == 0);
      items = $urandom_range(40, 120);
      kern_bias = $urandom_range(10, 90);
      alloc_pct = $urandom_range(35, 65);
      for (int i = 0; i < items; i++) begin
        r = $urandom_range(0, 99);
        kern = ($urandom_range(0, 99) < kern_bias);
        if (r < alloc_pct) send_request(CMD_ALLOC, kern, rand_addr());
        else if (r < 88) free_live_page(kern);
        else send_request(CMD_FREE, kern, noise_address(kern));
        if ($urandom_range(0, 49) == 0) wait_for_answers();
      end
    end
    no_idle = 1'b0;
  endtask

  always @(posedge clk) begin
    logic rdy;
    int   roll;
    rdy = 1'b1;
    if (!rst_n) begin
      rdy = 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      rdy = 1'b0;
    end else if (!no_idle) begin
      roll = $urandom_range(0, 99);
      if (roll < 12) begin
        stall_left <= $urandom_range(0, 2);
        rdy = 1'b0;
      end else if (roll < 15) begin
        stall_left <= $urandom_range(10, 60);
        rdy = 1'b0;
      end
    end
    out_ready <= rdy;
  end

  always @(posedge clk) begin
    page_answer_t want;
    if (rst_n && out_valid && out_ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("result word with nothing pending");
      end else begin
        want = answers_due.pop_front();
        if (out_result_address !== want.address)
          report_mismatch($sformatf("address %h, expected %h", out_result_address,
                                    want.address));
        if (out_status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, want.status));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pool_base[0] = '0;
    pool_base[1] = '0;
    pool_size[0] = SIZE_RST;
    pool_size[1] = SIZE_RST;
    for (int p = 0; p < 2; p++)
      for (int i = 0; i < POOL_PAGES; i++) taken_map[p][i] = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_special_cases();
    test_deep_fill();
    test_random_traffic();
    wait_for_answers();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (answers_due.size() != 0) report_mismatch("results still pending at end");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/bpa_pkg.sv
hw/rtl/bpa_ctrl.sv
hw/rtl/bpa_datapath.sv
hw/rtl/bitmap_page_allocator.sv
hw/rtl/bpa_checker.sv
tb/sv/bitmap_page_allocator_test.sv
